FILE: src/magic_length_frame_deframer_macros.svh
// Assertion macros used by the deframer checker.
`ifndef MAGIC_LENGTH_FRAME_DEFRAMER_MACROS_SVH
`define MAGIC_LENGTH_FRAME_DEFRAMER_MACROS_SVH

// Same-cycle implication, sampled on clk, quiet while arst_n is low.
`define MLFD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, quiet while arst_n is low.
`define MLFD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/mlfd_pkg.sv
// Shared constants and types of the magic-length frame deframer.
`timescale 1ns / 1ps
package mlfd_pkg;

	localparam int WINDOW_DEPTH  = 128;
	localparam int MAX_FRAME_LEN = 64;
	// A frame spans its length plus twelve header and trailer bytes and must fit the window.
	localparam int LEN_CAP = (MAX_FRAME_LEN < WINDOW_DEPTH - 12) ? MAX_FRAME_LEN
		: WINDOW_DEPTH - 12;

	localparam int HIST_DEPTH    = 128;
	localparam int HIST_AW       = $clog2(HIST_DEPTH);
	localparam int PTR_W         = HIST_AW + 1;
	localparam int LEN_W         = $clog2(MAX_FRAME_LEN + 1);

	localparam int FILL_MIN      = 8;
	localparam int FILL_W        = $clog2(FILL_MIN + 1);
	localparam int TRAILER_BYTES = 4;
	localparam int BODY_BACK     = 3;

	localparam int FRAME_Q_DEPTH = 2;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_BEGIN_MAGIC = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_END_MAGIC   = 2'd1;

	typedef struct packed {
		logic [PTR_W-1:0] start;
		logic [LEN_W-1:0] len;
	} mlfd_desc_t;

	typedef struct packed {
		logic       full;
		logic       empty;
		mlfd_desc_t head;
	} mlfd_qstat_t;

endpackage

FILE: src/mlfd_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module mlfd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end
endmodule

FILE: src/mlfd_queue.sv
// Small FIFO of completed frame descriptors between front and back.
`timescale 1ns / 1ps
module mlfd_queue #(
	parameter int DEPTH = mlfd_pkg::FRAME_Q_DEPTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  mlfd_pkg::mlfd_desc_t  push_desc,
	input  logic                  pop,
	output mlfd_pkg::mlfd_qstat_t stat
);
	import mlfd_pkg::*;

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	mlfd_desc_t     entry_q [DEPTH];
	logic [IW-1:0]  wr_idx_q;
	logic [IW-1:0]  rd_idx_q;
	logic [CW-1:0]  count_q;

	assign stat.full  = (count_q == CW'(DEPTH));
	assign stat.empty = (count_q == '0);
	assign stat.head  = entry_q[rd_idx_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_idx_q] <= push_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_idx_q <= '0;
			rd_idx_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_idx_q <= (wr_idx_q == IW'(DEPTH - 1)) ? '0 : wr_idx_q + 1'b1;
			end
			if (pop) begin
				rd_idx_q <= (rd_idx_q == IW'(DEPTH - 1)) ? '0 : rd_idx_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end
endmodule

FILE: src/mlfd_front.sv
// Front end: takes bytes, matches magics and lengths, queues completed frames.
`timescale 1ns / 1ps
module mlfd_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	input  logic [mlfd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [31:0]                     cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [7:0]                      rx_byte,
	input  mlfd_pkg::mlfd_qstat_t           qstat,
	output logic                            push,
	output mlfd_pkg::mlfd_desc_t            push_desc,
	output logic                            hist_we,
	output logic [mlfd_pkg::HIST_AW-1:0]    hist_addr,
	output logic [7:0]                      hist_data
);
	import mlfd_pkg::*;

	typedef enum logic [1:0] {
		F_IDLE = 2'b01,
		F_EVAL = 2'b10
	} front_state_t;

	front_state_t           state_q;
	logic [31:0]            begin_magic_q;
	logic [31:0]            end_magic_q;
	logic [63:0]            recent_q;
	logic [FILL_W-1:0]      fill_q;
	logic [PTR_W-1:0]       wr_ptr_q;
	logic [HIST_DEPTH-1:0]  cand_vld_q;

	logic                   accept;
	logic                   eval;
	logic [PTR_W-1:0]       head_span;
	logic                   guard;
	logic [HIST_AW-1:0]     cidx;
	logic [LEN_W-1:0]       cand_len;
	logic                   hit;
	logic [31:0]            lv;
	logic                   cap_ok;
	logic [HIST_AW-1:0]     target;
	logic                   cand_we;

	assign head_span = wr_ptr_q - qstat.head.start;
	assign guard     = !qstat.empty && (head_span >= PTR_W'(HIST_DEPTH));
	assign in_stall  = (state_q != F_IDLE) || qstat.full || guard;
	assign accept    = in_valid && !in_stall;
	assign eval      = (state_q == F_EVAL);
	assign cidx      = wr_ptr_q[HIST_AW-1:0];

	assign hist_we   = accept;
	assign hist_addr = cidx;
	assign hist_data = rx_byte;

	// Candidate lengths, indexed by the byte position at which the frame would end.
	mlfd_ram #(
		.WIDTH (LEN_W),
		.DEPTH (HIST_DEPTH)
	) u_cand_ram (
		.clk     (clk),
		.wr_en   (cand_we),
		.wr_addr (target),
		.wr_data (lv[LEN_W-1:0]),
		.rd_en   (accept),
		.rd_addr (cidx),
		.rd_data (cand_len)
	);

	assign hit    = eval && cand_vld_q[cidx] && (recent_q[31:0] == end_magic_q);
	assign lv     = recent_q[31:0];
	assign cap_ok = (fill_q >= FILL_W'(FILL_MIN)) && (recent_q[63:32] == begin_magic_q)
		&& (lv != '0) && (lv <= 32'(LEN_CAP));
	assign target = cidx + HIST_AW'(lv[LEN_W-1:0]) + HIST_AW'(TRAILER_BYTES);
	// An occupied slot already holds an earlier start, which wins.
	assign cand_we = eval && cap_ok && !hit && !cand_vld_q[target];

	assign push           = hit;
	assign push_desc.len  = cand_len;
	assign push_desc.start = wr_ptr_q - PTR_W'(cand_len) - PTR_W'(BODY_BACK);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			begin_magic_q <= '0;
			end_magic_q   <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_BEGIN_MAGIC: begin_magic_q <= cfg_data;
				REG_END_MAGIC:   end_magic_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= F_IDLE;
			recent_q   <= '0;
			fill_q     <= '0;
			wr_ptr_q   <= '0;
			cand_vld_q <= '0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (accept) begin
						recent_q <= {recent_q[55:0], rx_byte};
						if (fill_q < FILL_W'(FILL_MIN)) begin
							fill_q <= fill_q + 1'b1;
						end
						state_q <= F_EVAL;
					end
				end
				F_EVAL: begin
					wr_ptr_q <= wr_ptr_q + 1'b1;
					if (hit) begin
						cand_vld_q <= '0;
						recent_q   <= '0;
						fill_q     <= '0;
					end else begin
						cand_vld_q[cidx] <= 1'b0;
						if (cand_we) begin
							cand_vld_q[target] <= 1'b1;
						end
					end
					state_q <= F_IDLE;
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end
endmodule

FILE: src/mlfd_back.sv
// Back end: reads a queued frame from the history RAM and sends its results.
`timescale 1ns / 1ps
module mlfd_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mlfd_pkg::mlfd_qstat_t         qstat,
	output logic                          pop,
	output logic                          hist_re,
	output logic [mlfd_pkg::HIST_AW-1:0]  hist_addr,
	input  logic [7:0]                    hist_rdata,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [7:0]                    frame_type,
	output logic [7:0]                    payload_byte,
	output logic                          payload_valid,
	output logic                          last
);
	import mlfd_pkg::*;

	typedef enum logic [3:0] {
		B_IDLE  = 4'b0001,
		B_TYPE  = 4'b0010,
		B_PAY   = 4'b0100,
		B_EMPTY = 4'b1000
	} back_state_t;

	back_state_t         state_q;
	logic [LEN_W-1:0]    k_q;
	logic [7:0]          type_q;
	logic                out_valid_q;

	logic                out_free;
	logic                load;
	logic                load_last;
	logic                load_pv;
	logic [7:0]          load_byte;
	logic                is_last;
	logic [HIST_AW-1:0]  base;

	assign out_free = !out_valid_q || !out_stall;
	assign base     = qstat.head.start[HIST_AW-1:0];
	assign is_last  = (k_q == qstat.head.len - LEN_W'(1));

	always_comb begin
		hist_re   = 1'b0;
		hist_addr = base;
		pop       = 1'b0;
		load      = 1'b0;
		load_last = 1'b0;
		load_pv   = 1'b0;
		load_byte = '0;
		case (state_q)
			B_IDLE: begin
				hist_re = !qstat.empty;
			end
			B_TYPE: begin
				hist_re   = (qstat.head.len > LEN_W'(1));
				hist_addr = base + HIST_AW'(1);
			end
			B_PAY: begin
				if (out_free) begin
					load      = 1'b1;
					load_pv   = 1'b1;
					load_byte = hist_rdata;
					load_last = is_last;
					pop       = is_last;
					hist_re   = !is_last;
					hist_addr = base + HIST_AW'(k_q) + HIST_AW'(1);
				end
			end
			B_EMPTY: begin
				if (out_free) begin
					load      = 1'b1;
					load_last = 1'b1;
					pop       = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				B_IDLE: begin
					if (!qstat.empty) begin
						state_q <= B_TYPE;
					end
				end
				B_TYPE: begin
					k_q     <= LEN_W'(1);
					state_q <= (qstat.head.len > LEN_W'(1)) ? B_PAY : B_EMPTY;
				end
				B_PAY: begin
					if (load) begin
						if (is_last) begin
							state_q <= B_IDLE;
						end else begin
							k_q <= k_q + 1'b1;
						end
					end
				end
				B_EMPTY: begin
					if (load) begin
						state_q <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == B_TYPE) begin
			type_q <= hist_rdata;
		end
		if (load) begin
			frame_type    <= type_q;
			payload_byte  <= load_byte;
			payload_valid <= load_pv;
			last          <= load_last;
		end
	end

	assign out_valid = out_valid_q;
endmodule

FILE: src/magic_length_frame_deframer.sv
// Input stalls while the front end evaluates a byte, while the descriptor queue is full, or
// while the 128-byte history would overwrite a frame not yet read out. The byte that closes a
// frame passes front evaluation, the descriptor queue and the back end's idle and type states
// into the output register, then one result per cycle follows while the output is not stalled.
// Reset (arst_n low) clears magics to zero and drops all state.
`timescale 1ns / 1ps
module magic_length_frame_deframer #(
	parameter int FRAME_Q_DEPTH = mlfd_pkg::FRAME_Q_DEPTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// Configuration write channel; always ready.
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [mlfd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [31:0]                     cfg_data,
	// Received byte stream.
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [7:0]                      rx_byte,
	// Frame results, one transfer per payload byte, or one transfer marked last for an empty payload.
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [7:0]                      frame_type,
	output logic [7:0]                      payload_byte,
	output logic                            payload_valid,
	output logic                            last
);
	import mlfd_pkg::*;

	mlfd_qstat_t         qstat;
	mlfd_desc_t          push_desc;
	logic                push;
	logic                pop;
	logic                hist_we;
	logic [HIST_AW-1:0]  hist_waddr;
	logic [7:0]          hist_wdata;
	logic                hist_re;
	logic [HIST_AW-1:0]  hist_raddr;
	logic [7:0]          hist_rdata;

	// Register writes never wait.
	assign cfg_ready = 1'b1;

	// The front end writes every received byte into the history at its running position,
	// tracks begin candidates by the position at which they would end, and queues a
	// descriptor (body start, length) when the end magic closes one.
	mlfd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.rx_byte   (rx_byte),
		.qstat     (qstat),
		.push      (push),
		.push_desc (push_desc),
		.hist_we   (hist_we),
		.hist_addr (hist_waddr),
		.hist_data (hist_wdata)
	);

	// Byte history shared by both sides: front writes, back reads.
	mlfd_ram #(
		.WIDTH (8),
		.DEPTH (HIST_DEPTH)
	) u_hist_ram (
		.clk     (clk),
		.wr_en   (hist_we),
		.wr_addr (hist_waddr),
		.wr_data (hist_wdata),
		.rd_en   (hist_re),
		.rd_addr (hist_raddr),
		.rd_data (hist_rdata)
	);

	// Completed frames wait here so the two sides stall independently.
	mlfd_queue #(
		.DEPTH (FRAME_Q_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_desc (push_desc),
		.pop       (pop),
		.stat      (qstat)
	);

	// The back end reads the type byte, then one payload byte per transfer.
	mlfd_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.qstat         (qstat),
		.pop           (pop),
		.hist_re       (hist_re),
		.hist_addr     (hist_raddr),
		.hist_rdata    (hist_rdata),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.frame_type    (frame_type),
		.payload_byte  (payload_byte),
		.payload_valid (payload_valid),
		.last          (last)
	);
endmodule

FILE: src/mlfd_checker.sv
// Port-level checker of the deframer, bound to the top level.
`timescale 1ns / 1ps
`include "magic_length_frame_deframer_macros.svh"
module mlfd_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_valid,
	input logic                            in_stall,
	input logic                            out_valid,
	input logic                            out_stall,
	input logic [7:0]                      frame_type,
	input logic [7:0]                      payload_byte,
	input logic                            payload_valid,
	input logic                            last
);
	`MLFD_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
		out_valid && $stable(payload_byte) && $stable(last), "stalled result changed")
	`MLFD_ASSERT_NOW(a_empty_is_last, out_valid && !payload_valid, last,
		"empty payload result not marked last")
	`MLFD_ASSERT_NEXT(a_type_steady, out_valid && !out_stall && !last,
		frame_type == $past(frame_type), "frame type changed inside a frame")
	`MLFD_ASSERT_NEXT(a_in_two_cycle, in_valid && !in_stall, in_stall,
		"byte taken while previous byte still in evaluation")
endmodule

bind magic_length_frame_deframer mlfd_checker u_mlfd_checker (.*);
